// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// File: src/bkat_pkg.sv
// ---------------------------------------------------------------------------
// bkat_pkg
// shared constants and types of the key allocator
// ---------------------------------------------------------------------------
package bkat_pkg;

   localparam int CAPACITY    = 256;
   localparam int WORD_BITS   = 64;
   localparam int HANDLE_BITS = 32;

   localparam int NUM_WORDS   = CAPACITY / WORD_BITS;
   localparam int KEY_BITS    = $clog2(CAPACITY);
   localparam int LIMIT_BITS  = $clog2(CAPACITY + 1);
   localparam int POS_BITS    = $clog2(WORD_BITS);
   localparam int WIDX_BITS   = KEY_BITS - POS_BITS;

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_RESERVE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DISPOSE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LOOK    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_SET     = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(CAPACITY);

   // result of searching one bitmap word
   typedef struct packed {
      logic                hit;
      logic [POS_BITS-1:0] pos;
   } scan_res_type;

endpackage

// File: src/bitmap_key_allocator_table.sv
// ---------------------------------------------------------------------------
// bitmap_key_allocator_table
// key allocator: used-key bitmap, search hint and per-key handle table
// ---------------------------------------------------------------------------
// One request at a time. Reserve scans the bitmap memory one 64-bit word per
// cycle from the word holding the search hint, visiting 1 to 4 words before
// its result is ready; dispose and look first pass through the clear or look
// state (memory read, then write back or data return), while set, every
// out-of-range request and a reserve whose hint is at or above the limit go
// straight to done. The sequencer returns to idle as the result enters the
// rsp output register, and the next request is taken in the following cycle.
// The pace is set by the single registered read port of the bitmap memory. A
// finished result sits in the rsp output register, so the next request is
// taken while it waits. The handle table and bitmap are cleared at reset by
// per-entry (handle) and per-word (bitmap) valid flops, so no clearing pass is
// needed and requests are taken in the first cycle after reset. key_limit
// must be written through csr_we only while no request is in flight; the
// block does not enforce this. Values above 256 act as 256.
`include "assert_macros.svh"

module bitmap_key_allocator_table (
   input  logic        clock,
   input  logic        reset,
   // request: opcode[1:0], key[9:2], handle_in[41:10], zero pad above
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // response: key_out[7:0], handle_out[39:8], status[41:40], zero pad above
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // key_limit register
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);

   localparam int KB = bkat_pkg::KEY_BITS;
   localparam int LB = bkat_pkg::LIMIT_BITS;
   localparam int PB = bkat_pkg::POS_BITS;
   localparam int WB = bkat_pkg::WIDX_BITS;
   localparam int HB = bkat_pkg::HANDLE_BITS;
   localparam int DW = bkat_pkg::WORD_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_CLEAR = 5'b00100,
      S_LOOK  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // request fields
   logic [bkat_pkg::OP_BITS-1:0] req_opcode;
   logic [KB-1:0]                req_key;
   logic [HB-1:0]                req_handle;
   logic                         req_xfer;

   assign req_opcode = req_tdata[1:0];
   assign req_key    = req_tdata[9:2];
   assign req_handle = req_tdata[41:10];
   assign req_xfer   = req_tvalid && req_tready;

   // control registers
   state_type                        state_ff, state_in;
   logic [LB-1:0]                    limit_ff;
   logic [LB-1:0]                    hint_ff, hint_in;
   logic [WB-1:0]                    word_ff, word_in;
   logic [KB-1:0]                    key_ff, key_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // pending result and output register
   logic [KB-1:0]                    res_key_ff, res_key_in;
   logic [HB-1:0]                    res_handle_ff, res_handle_in;
   logic [bkat_pkg::STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [KB-1:0]                    rsp_key_ff;
   logic [HB-1:0]                    rsp_handle_ff;
   logic [bkat_pkg::STATUS_BITS-1:0] rsp_status_ff;

   // valid flops standing in for the reset clear of both memories
   logic [bkat_pkg::NUM_WORDS-1:0]   wvld_ff;
   logic [bkat_pkg::CAPACITY-1:0]    hvld_ff;
   logic                             wvld_q_ff;
   logic                             hvld_q_ff;

   // memory ports
   logic          bm_we;
   logic [WB-1:0] bm_waddr;
   logic [DW-1:0] bm_wdata;
   logic [WB-1:0] bm_raddr;
   logic [DW-1:0] bm_rdata;
   logic [DW-1:0] bm_word;
   logic          hm_we;
   logic [HB-1:0] hm_rdata;

   logic [LB-1:0] lim;
   logic          in_range;
   logic [LB-1:0] next_base;
   logic          last_word;
   logic          rsp_load;
   bkat_pkg::scan_res_type scan;

   // limit above capacity acts as capacity
   assign lim = (limit_ff > bkat_pkg::LIMIT_RESET) ? bkat_pkg::LIMIT_RESET : limit_ff;
   assign in_range = LB'(req_key) < lim;

   assign bm_word = wvld_q_ff ? bm_rdata : '0;

   // no more words once the next one starts at or above the limit
   assign next_base = (LB'(word_ff) + LB'(1)) << PB;
   assign last_word = (word_ff == WB'(bkat_pkg::NUM_WORDS - 1)) || (next_base >= lim);

   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE);

   bkat_scan u_scan (
      .word  (bm_word),
      .widx  (word_ff),
      .hint  (hint_ff),
      .limit (lim),
      .res   (scan)
   );

   bkat_ram #(
      .DEPTH (bkat_pkg::NUM_WORDS),
      .WIDTH (DW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   // handle table is read at the request key on every cycle
   bkat_ram #(
      .DEPTH (bkat_pkg::CAPACITY),
      .WIDTH (HB)
   ) u_handles (
      .clock   (clock),
      .wr_en   (hm_we),
      .wr_addr (req_key),
      .wr_data (req_handle),
      .rd_addr (req_key),
      .rd_data (hm_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      hint_in       = hint_ff;
      word_in       = word_ff;
      key_in        = key_ff;
      res_key_in    = res_key_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      bm_we         = 1'b0;
      bm_waddr      = word_ff;
      bm_wdata      = bm_word;
      bm_raddr      = word_ff;
      hm_we         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // read the word that the request will need
            if (req_opcode == bkat_pkg::OP_RESERVE) begin
               bm_raddr = hint_ff[KB-1:PB];
            end else begin
               bm_raddr = req_key[KB-1:PB];
            end
            if (req_xfer) begin
               key_in        = req_key;
               res_key_in    = req_key;
               res_handle_in = '0;
               res_status_in = bkat_pkg::ST_OK;
               if (req_opcode == bkat_pkg::OP_RESERVE) begin
                  if (hint_ff >= lim) begin
                     res_key_in    = '0;
                     res_status_in = bkat_pkg::ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     word_in  = hint_ff[KB-1:PB];
                     state_in = S_SCAN;
                  end
               end else if (!in_range) begin
                  res_status_in = bkat_pkg::ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  case (req_opcode)
                     bkat_pkg::OP_DISPOSE: state_in = S_CLEAR;
                     bkat_pkg::OP_LOOK:    state_in = S_LOOK;
                     default: begin
                        hm_we    = 1'b1;
                        state_in = S_DONE;
                     end
                  endcase
               end
            end
         end

         S_SCAN: begin
            if (scan.hit) begin
               bm_we         = 1'b1;
               bm_wdata      = bm_word | (DW'(1) << scan.pos);
               hint_in       = LB'({word_ff, scan.pos}) + LB'(1);
               res_key_in    = {word_ff, scan.pos};
               res_status_in = bkat_pkg::ST_OK;
               state_in      = S_DONE;
            end else if (last_word) begin
               res_key_in    = '0;
               res_status_in = bkat_pkg::ST_FULL;
               state_in      = S_DONE;
            end else begin
               // fetch the next word, examined next cycle
               word_in  = word_ff + WB'(1);
               bm_raddr = word_ff + WB'(1);
            end
         end

         S_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = key_ff[KB-1:PB];
            bm_wdata = bm_word & ~(DW'(1) << key_ff[PB-1:0]);
            if (LB'(key_ff) < hint_ff) begin
               hint_in = LB'(key_ff);
            end
            state_in = S_DONE;
         end

         S_LOOK: begin
            res_handle_in = hvld_q_ff ? hm_rdata : '0;
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hint_ff      <= '0;
         limit_ff     <= bkat_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         wvld_ff      <= '0;
         hvld_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (bm_we) begin
            wvld_ff[bm_waddr] <= 1'b1;
         end
         if (hm_we) begin
            hvld_ff[req_key] <= 1'b1;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      key_ff        <= key_in;
      res_key_ff    <= res_key_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      // valid bits sampled with the memory read so they line up with the data
      wvld_q_ff     <= wvld_ff[bm_raddr];
      hvld_q_ff     <= hvld_ff[req_key];
      if (rsp_load) begin
         rsp_key_ff    <= res_key_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_handle_ff, rsp_key_ff};

   // hint never runs past the capacity
   `ASSERT_PROP(a_hint_bound, clock, reset, hint_ff <= bkat_pkg::LIMIT_RESET)
   // a reserve that finds a key finishes right away
   `ASSERT_PROP(a_hit_done, clock, reset, (state_ff == S_SCAN && scan.hit) |=> (state_ff == S_DONE))
   // out-of-range results never carry a handle
   `ASSERT_NEVER(a_range_handle, clock, reset, rsp_valid_ff && rsp_status_ff == bkat_pkg::ST_RANGE && rsp_handle_ff != '0)
   // status never goes past the out-of-range code
   `ASSERT_NEVER(a_status_code, clock, reset, rsp_valid_ff && rsp_status_ff > bkat_pkg::ST_RANGE)

endmodule

// File: src/bkat_ram.sv
// ---------------------------------------------------------------------------
// bkat_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module bkat_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bkat_scan.sv
// ---------------------------------------------------------------------------
// bkat_scan
// finds the lowest free key of one bitmap word inside [hint, limit)
// ---------------------------------------------------------------------------
module bkat_scan (
   input  logic [bkat_pkg::WORD_BITS-1:0]  word,
   input  logic [bkat_pkg::WIDX_BITS-1:0]  widx,
   input  logic [bkat_pkg::LIMIT_BITS-1:0] hint,
   input  logic [bkat_pkg::LIMIT_BITS-1:0] limit,
   output bkat_pkg::scan_res_type          res
);

   logic [bkat_pkg::WORD_BITS-1:0] cand;

   always_comb begin
      logic [bkat_pkg::LIMIT_BITS-1:0] k;
      for (int i = 0; i < bkat_pkg::WORD_BITS; i++) begin
         k = bkat_pkg::LIMIT_BITS'({widx, bkat_pkg::POS_BITS'(i)});
         cand[i] = !word[i] && (k >= hint) && (k < limit);
      end
   end

   // lowest set candidate wins
   always_comb begin
      res.hit = |cand;
      res.pos = '0;
      for (int i = bkat_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            res.pos = bkat_pkg::POS_BITS'(i);
         end
      end
   end

endmodule
